### src/lvl_pkg.sv
// ----------------------------------------------------------------------------
// lvl_pkg
// Shared widths, register map, reset values and pipeline control type for
// the vertex lighting block.
// ----------------------------------------------------------------------------
package lvl_pkg;

    // field and intermediate widths
    localparam int IN_W   = 16;
    localparam int DIFF_W = 17;
    localparam int NN_W   = 32;
    localparam int DD_W   = 34;
    localparam int DOT_W  = 33;
    localparam int SUM_W  = 35;
    localparam int WIDE_W = 66;
    localparam int QUO_W  = 31;
    localparam int ROOT_W = 16;
    localparam int SQ_W   = 33;

    // register map
    localparam logic REG_AMBIENT = 1'b0;
    localparam logic REG_DIFFUSE = 1'b1;

    localparam logic [15:0] AMBIENT_RESET = 16'd9830;
    localparam logic [15:0] DIFFUSE_RESET = 16'd22938;

    localparam logic [15:0] INTENSITY_ONE = 16'd32768;

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic zero;
    } pipe_ctl_t;

endpackage

### src/lvl_div.sv
// ----------------------------------------------------------------------------
// lvl_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor((sq << 30) / div), where the quotient is known to fit in 31 bits.
// ----------------------------------------------------------------------------
module lvl_div
    import lvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  pipe_ctl_t         ctl_in,
    input  logic [WIDE_W-1:0] div_in,
    input  logic [WIDE_W-1:0] sq_in,
    output pipe_ctl_t         ctl_out,
    output logic [QUO_W-1:0]  quot
);

    pipe_ctl_t         ctl_reg  [QUO_W];
    logic [WIDE_W-1:0] rem_reg  [QUO_W];
    logic [WIDE_W-1:0] div_reg  [QUO_W];
    logic [QUO_W-1:0]  quot_reg [QUO_W];

    logic [WIDE_W-1:0] rem_next  [QUO_W];
    logic [QUO_W-1:0]  quot_next [QUO_W];

    // one trial subtract per stage
    always_comb
    begin
        logic [WIDE_W-1:0] rem_src;
        logic [WIDE_W-1:0] div_src;
        logic [QUO_W-1:0]  quot_src;
        logic              feed;
        logic [WIDE_W:0]   trial;
        logic [WIDE_W:0]   diff;
        logic              ge;
        for (int i = 0; i < QUO_W; i++)
        begin
            if (i == 0)
            begin
                rem_src  = {1'b0, sq_in[WIDE_W-1:1]};
                div_src  = div_in;
                quot_src = '0;
                feed     = sq_in[0];
            end
            else
            begin
                rem_src  = rem_reg[i-1];
                div_src  = div_reg[i-1];
                quot_src = quot_reg[i-1];
                feed     = 1'b0;
            end
            trial        = {rem_src, feed};
            diff         = trial - {1'b0, div_src};
            ge           = (trial >= {1'b0, div_src});
            rem_next[i]  = ge ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
            quot_next[i] = {quot_src[QUO_W-2:0], ge};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
                div_reg[i]  <= (i == 0) ? div_in : div_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                ctl_reg[i] <= (i == 0) ? ctl_in : ctl_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign ctl_out = ctl_reg[QUO_W-1];
    assign quot    = quot_reg[QUO_W-1];

endmodule

### src/lvl_isqrt.sv
// ----------------------------------------------------------------------------
// lvl_isqrt
// Pipelined integer square root, one root bit per stage, tracking the
// square of the partial root so no multiplier is needed.
// ----------------------------------------------------------------------------
module lvl_isqrt
    import lvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  pipe_ctl_t         ctl_in,
    input  logic [QUO_W-1:0]  rad_in,
    output pipe_ctl_t         ctl_out,
    output logic [ROOT_W-1:0] root
);

    pipe_ctl_t         ctl_reg  [ROOT_W];
    logic [QUO_W-1:0]  rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SQ_W-1:0]   sq_reg   [ROOT_W];

    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [SQ_W-1:0]   sq_next   [ROOT_W];

    // try setting one root bit per stage, msb first
    always_comb
    begin
        logic [QUO_W-1:0]  rad_src;
        logic [ROOT_W-1:0] root_src;
        logic [SQ_W-1:0]   sq_src;
        logic [SQ_W-1:0]   cand;
        int                k;
        for (int i = 0; i < ROOT_W; i++)
        begin
            k = ROOT_W - 1 - i;
            if (i == 0)
            begin
                rad_src  = rad_in;
                root_src = '0;
                sq_src   = '0;
            end
            else
            begin
                rad_src  = rad_reg[i-1];
                root_src = root_reg[i-1];
                sq_src   = sq_reg[i-1];
            end
            cand = sq_src + (SQ_W'(root_src) << (k + 1)) + (SQ_W'(1) << (2 * k));
            if (cand <= SQ_W'(rad_src))
            begin
                root_next[i] = root_src | (ROOT_W'(1) << k);
                sq_next[i]   = cand;
            end
            else
            begin
                root_next[i] = root_src;
                sq_next[i]   = sq_src;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                root_reg[i] <= root_next[i];
                sq_reg[i]   <= sq_next[i];
                rad_reg[i]  <= (i == 0) ? rad_in : rad_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                ctl_reg[i] <= (i == 0) ? ctl_in : ctl_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign ctl_out = ctl_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];

endmodule

### src/lambert_vertex_light.sv
// Throughput: one item per cycle while not stalled; the pipeline is 4 setup
// stages, a 31-stage divider, a 16-stage square root and 2 shading stages.
// A stall on the output freezes the whole pipeline for that cycle.
// Reset (async, active low) empties the pipeline and loads default registers.
// ----------------------------------------------------------------------------
// lambert_vertex_light
// Per-vertex Lambert diffuse lighting: clamped cosine between the normal and
// the vertex-to-light vector, then ambient plus scaled diffuse term.
// ----------------------------------------------------------------------------
module lambert_vertex_light
    import lvl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // apb configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input item
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  light_x,
    input  logic signed [IN_W-1:0]  light_y,
    input  logic signed [IN_W-1:0]  light_z,
    input  logic signed [IN_W-1:0]  point_x,
    input  logic signed [IN_W-1:0]  point_y,
    input  logic signed [IN_W-1:0]  point_z,
    input  logic signed [IN_W-1:0]  normal_x,
    input  logic signed [IN_W-1:0]  normal_y,
    input  logic signed [IN_W-1:0]  normal_z,
    // result item
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [15:0]             intensity,
    output logic [15:0]             shade
);

    logic en;

    // configuration registers
    logic [15:0] ambient_reg;
    logic [15:0] diffuse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= AMBIENT_RESET;
            diffuse_reg <= DIFFUSE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_AMBIENT: ambient_reg <= pwdata[15:0];
                REG_DIFFUSE: diffuse_reg <= pwdata[15:0];
                default:     ambient_reg <= ambient_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'b0, (paddr[2] == REG_DIFFUSE) ? diffuse_reg : ambient_reg};

    // global advance
    logic out_valid_reg;
    assign in_stall = out_valid_reg && out_stall;
    assign en       = !in_stall;

    // stage 1: direction and normal
    logic [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [IN_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic              v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DIFF_W'(light_x) - DIFF_W'(point_x);
            dy_reg <= DIFF_W'(light_y) - DIFF_W'(point_y);
            dz_reg <= DIFF_W'(light_z) - DIFF_W'(point_z);
            nx_reg <= normal_x;
            ny_reg <= normal_y;
            nz_reg <= normal_z;
        end
    end

    // stage 2: component products, modulo arithmetic on sign-extended values
    logic [DOT_W-1:0] px_reg, py_reg, pz_reg;
    logic [NN_W-1:0]  nnx_reg, nny_reg, nnz_reg;
    logic [DD_W-1:0]  ddx_reg, ddy_reg, ddz_reg;
    logic             v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= {{(DOT_W-IN_W){nx_reg[IN_W-1]}}, nx_reg}
                     * {{(DOT_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
            py_reg  <= {{(DOT_W-IN_W){ny_reg[IN_W-1]}}, ny_reg}
                     * {{(DOT_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
            pz_reg  <= {{(DOT_W-IN_W){nz_reg[IN_W-1]}}, nz_reg}
                     * {{(DOT_W-DIFF_W){dz_reg[DIFF_W-1]}}, dz_reg};
            nnx_reg <= {{(NN_W-IN_W){nx_reg[IN_W-1]}}, nx_reg}
                     * {{(NN_W-IN_W){nx_reg[IN_W-1]}}, nx_reg};
            nny_reg <= {{(NN_W-IN_W){ny_reg[IN_W-1]}}, ny_reg}
                     * {{(NN_W-IN_W){ny_reg[IN_W-1]}}, ny_reg};
            nnz_reg <= {{(NN_W-IN_W){nz_reg[IN_W-1]}}, nz_reg}
                     * {{(NN_W-IN_W){nz_reg[IN_W-1]}}, nz_reg};
            ddx_reg <= {{(DD_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg}
                     * {{(DD_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
            ddy_reg <= {{(DD_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg}
                     * {{(DD_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
            ddz_reg <= {{(DD_W-DIFF_W){dz_reg[DIFF_W-1]}}, dz_reg}
                     * {{(DD_W-DIFF_W){dz_reg[DIFF_W-1]}}, dz_reg};
        end
    end

    // stage 3: sums and the zero-intensity flag
    logic [SUM_W-1:0] dot_sum;
    logic [NN_W-1:0]  nn_sum;
    logic [DD_W-1:0]  dd_sum;

    assign dot_sum = {{(SUM_W-DOT_W){px_reg[DOT_W-1]}}, px_reg}
                   + {{(SUM_W-DOT_W){py_reg[DOT_W-1]}}, py_reg}
                   + {{(SUM_W-DOT_W){pz_reg[DOT_W-1]}}, pz_reg};
    assign nn_sum  = nnx_reg + nny_reg + nnz_reg;
    assign dd_sum  = ddx_reg + ddy_reg + ddz_reg;

    logic [DOT_W-1:0] dot_reg;
    logic [NN_W-1:0]  nn_reg;
    logic [DD_W-1:0]  dd_reg;
    logic             zero3_reg;
    logic             v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg   <= dot_sum[DOT_W-1:0];
            nn_reg    <= nn_sum;
            dd_reg    <= dd_sum;
            zero3_reg <= (nn_sum == '0) || (dd_sum == '0)
                      || dot_sum[SUM_W-1] || (dot_sum == '0);
        end
    end

    // stage 4: length product and squared dot
    logic [WIDE_W-1:0] len_reg;
    logic [WIDE_W-1:0] dsq_reg;
    pipe_ctl_t         ctl4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= WIDE_W'(nn_reg) * WIDE_W'(dd_reg);
            dsq_reg <= WIDE_W'(dot_reg) * WIDE_W'(dot_reg);
        end
    end

    // valid bits of the setup stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            v1_reg         <= in_valid;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            ctl4_reg.valid <= v3_reg;
            ctl4_reg.zero  <= zero3_reg;
        end
    end

    // cos^2 scaled by 2^30, then its root
    pipe_ctl_t         div_ctl;
    logic [QUO_W-1:0]  ratio;
    pipe_ctl_t         root_ctl;
    logic [ROOT_W-1:0] root;

    lvl_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl4_reg),
        .div_in  (len_reg),
        .sq_in   (dsq_reg),
        .ctl_out (div_ctl),
        .quot    (ratio)
    );

    lvl_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (div_ctl),
        .rad_in  (ratio),
        .ctl_out (root_ctl),
        .root    (root)
    );

    // shading stage: diffuse product
    logic [15:0] inten_m_reg;
    logic [31:0] prod_m_reg;
    logic        vm_reg;
    logic [15:0] inten_m;

    assign inten_m = root_ctl.zero ? 16'd0 : root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inten_m_reg <= inten_m;
            prod_m_reg  <= 32'(inten_m) * 32'(diffuse_reg);
        end
    end

    // output stage: ambient add and saturation
    logic [17:0] shade_sum;
    logic [15:0] intensity_reg;
    logic [15:0] shade_reg;

    assign shade_sum = {2'b0, ambient_reg} + {1'b0, prod_m_reg[31:15]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            intensity_reg <= inten_m_reg;
            shade_reg     <= (shade_sum[17:16] != 2'b0) ? 16'hFFFF : shade_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg        <= root_ctl.valid;
            out_valid_reg <= vm_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;
    assign shade     = shade_reg;

`ifndef ASSERT_OFF
    // cosine never exceeds one
    a_inten_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intensity <= INTENSITY_ONE))
        else $error("intensity above one");

    // unlit vertex shows ambient alone
    a_ambient_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (intensity == 16'd0)) |-> (shade == ambient_reg))
        else $error("shade differs from ambient at zero intensity");

    // a stalled result is held by the frozen pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(shade)
                                      && $stable(intensity)))
        else $error("stalled result lost");

    // input is never held off while no result waits
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid) |-> !in_stall)
        else $error("input stalled with empty output");
`endif

endmodule
